// ----- rtl/onds_pkg.sv -----
// ----------------------------------------------------------------------------
// onds_pkg
// shared types, constants and the digit-to-symbol mapping of the
// order number to digit symbols block
// ----------------------------------------------------------------------------
package onds_pkg;

    localparam int DIGIT_W     = 6;
    localparam int SYMBOL_W    = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int TABLE_SLOTS = 12;
    localparam int TABLE_W     = TABLE_SLOTS * SYMBOL_W;

    localparam logic [DIGIT_W-1:0] BASE_MIN = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX = 6'd37;

    // register indexes, address bits 5..3
    localparam logic [2:0] REG_DIGIT_BASE   = 3'd0;
    localparam logic [2:0] REG_USE_TABLE    = 3'd1;
    localparam logic [2:0] REG_RANGE_START  = 3'd2;
    localparam logic [2:0] REG_SYMBOLS_LOW  = 3'd3;
    localparam logic [2:0] REG_SYMBOLS_MID  = 3'd4;
    localparam logic [2:0] REG_SYMBOLS_HIGH = 3'd5;

    typedef struct packed {
        logic [DIGIT_W-1:0]  digit_base;
        logic                use_symbol_table;
        logic [SYMBOL_W-1:0] range_start;
        logic [TABLE_W-1:0]  symbols;     // symbol 0 in the lowest bits
    } cfg_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

    function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] base);
        logic [DIGIT_W-1:0] b;
        b = base;
        if (base < BASE_MIN)
        begin
            b = BASE_MIN;
        end
        else if (base > BASE_MAX)
        begin
            b = BASE_MAX;
        end
        return b;
    endfunction

    function automatic logic [SYMBOL_W-1:0] symbol_for(
        input logic [DIGIT_W-1:0] digit,
        input cfg_t               cfg,
        input int                 entries
    );
        logic [SYMBOL_W-1:0] code;
        logic [3:0]          slot;
        slot = digit[3:0];
        code = '0;
        if (!cfg.use_symbol_table)
        begin
            code = cfg.range_start + {{(SYMBOL_W-DIGIT_W){1'b0}}, digit};
        end
        else if (int'(digit) < entries && int'(digit) < TABLE_SLOTS)
        begin
            code = cfg.symbols[slot*SYMBOL_W +: SYMBOL_W];
        end
        return code;
    endfunction

endpackage

// ----- rtl/onds_cfg.sv -----
// ----------------------------------------------------------------------------
// onds_cfg
// apb register file: digit base, mode, range start and symbol table
// ----------------------------------------------------------------------------
module onds_cfg
    import onds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [DIGIT_W-1:0]    base_reg;
    logic                  use_tab_reg;
    logic [SYMBOL_W-1:0]   start_reg;
    logic [CFG_DATA_W-1:0] sym_low_reg;
    logic [CFG_DATA_W-1:0] sym_mid_reg;
    logic [CFG_DATA_W-1:0] sym_high_reg;
    logic [2:0]            index;
    logic                  wr_en;

    assign pready = 1'b1;
    assign index  = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= 6'd26;
            use_tab_reg  <= 1'b0;
            start_reg    <= 16'd97;
            sym_low_reg  <= '0;
            sym_mid_reg  <= '0;
            sym_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DIGIT_BASE:   base_reg     <= pwdata[DIGIT_W-1:0];
                REG_USE_TABLE:    use_tab_reg  <= pwdata[0];
                REG_RANGE_START:  start_reg    <= pwdata[SYMBOL_W-1:0];
                REG_SYMBOLS_LOW:  sym_low_reg  <= pwdata;
                REG_SYMBOLS_MID:  sym_mid_reg  <= pwdata;
                REG_SYMBOLS_HIGH: sym_high_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DIGIT_BASE:   prdata = {{(CFG_DATA_W-DIGIT_W){1'b0}}, base_reg};
            REG_USE_TABLE:    prdata = {{(CFG_DATA_W-1){1'b0}}, use_tab_reg};
            REG_RANGE_START:  prdata = {{(CFG_DATA_W-SYMBOL_W){1'b0}}, start_reg};
            REG_SYMBOLS_LOW:  prdata = sym_low_reg;
            REG_SYMBOLS_MID:  prdata = sym_mid_reg;
            REG_SYMBOLS_HIGH: prdata = sym_high_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.digit_base       = base_reg;
    assign cfg.use_symbol_table = use_tab_reg;
    assign cfg.range_start      = start_reg;
    assign cfg.symbols          = {sym_high_reg, sym_mid_reg, sym_low_reg};

endmodule

// ----- rtl/onds_divider.sv -----
// ----------------------------------------------------------------------------
// onds_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module onds_divider
    import onds_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIGIT_W-1:0]     base,
    output logic [VALUE_WIDTH-1:0] quotient,
    output div_status_t            status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [DIGIT_W-1:0]     base_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       diff;
    logic                   ge;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, value_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, base_reg};
    assign ge    = trial >= {1'b0, base_reg};

    always_comb
    begin
        value_next = value_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            value_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_W'(VALUE_WIDTH);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            value_next = {value_reg[VALUE_WIDTH-2:0], ge};
            rem_next   = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rem_reg   <= rem_next;
        if (start)
        begin
            base_reg <= base;
        end
    end

    assign quotient         = value_reg;
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule

// ----- rtl/onds_digit_store.sv -----
// ----------------------------------------------------------------------------
// onds_digit_store
// digit memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module onds_digit_store
    import onds_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [DIGIT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [DIGIT_W-1:0] rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/order_number_to_digit_symbols.sv -----
// ----------------------------------------------------------------------------
// order_number_to_digit_symbols
// writes an unsigned order number in a configured base as a stream of
// digit symbols, most significant digit first
// ----------------------------------------------------------------------------
// One number is taken at a time. Each digit comes from a bit-serial divide by
// the base; the digits go to a small memory least significant first and are
// then read back in reverse, one memory read and one output load per word,
// the load waiting while the sink stalls. Zero gives the single digit 0; a
// number that needs more than MAX_DIGITS digits gives only its MAX_DIGITS
// lowest ones. The base is clamped into 2..37. In range mode a symbol is
// range_start plus the digit, modulo 2^16; in table mode it is the table
// entry, and 0 for a digit at or past TABLE_ENTRIES. The final digit of a
// number carries tlast, and the next number may be taken while that final
// word still waits at the output.
// ----------------------------------------------------------------------------
module order_number_to_digit_symbols
    import onds_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int MAX_DIGITS    = 32,
    parameter int TABLE_ENTRIES = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // order_value
    // output words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // symbol_code, digit_value
    output logic                                m_tlast,   // last_digit
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [CFG_ADDR_W-1:0]               paddr,
    input  logic [CFG_DATA_W-1:0]               pwdata,
    output logic [CFG_DATA_W-1:0]               prdata,
    output logic                                pready
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    cfg_t                   cfg;
    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0]       count_reg, count_next;      // digits produced so far
    logic [ADDR_W-1:0]      idx_reg, idx_next;          // readback address
    logic [SYMBOL_W-1:0]    sym_reg;
    logic [DIGIT_W-1:0]     dig_reg;
    logic                   last_reg;
    logic                   out_valid_reg, out_valid_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] quotient;
    div_status_t            div_status;
    logic                   wr_en;
    logic                   rd_en;
    logic [DIGIT_W-1:0]     rd_data;
    logic                   load;

    onds_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    onds_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (remaining_reg),
        .base     (clamp_base(cfg.digit_base)),
        .quotient (quotient),
        .status   (div_status)
    );

    onds_digit_store #(.DEPTH(MAX_DIGITS), .ADDR_W(ADDR_W)) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (div_status.remainder),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remaining_reg <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word register, loaded from the memory read data
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg  <= symbol_for(rd_data, cfg, TABLE_ENTRIES);
            dig_reg  <= rd_data;
            last_reg <= (idx_reg == '0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        s_tready       = 1'b0;
        div_start      = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        load           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    remaining_next = s_tdata[VALUE_WIDTH-1:0];
                    count_next     = '0;
                    state_next     = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    // store this digit, carry the quotient on
                    wr_en          = 1'b1;
                    remaining_next = quotient;
                    count_next     = count_reg + 1'b1;
                    if (quotient == '0 || count_reg == CNT_W'(MAX_DIGITS - 1))
                    begin
                        idx_next   = count_reg[ADDR_W-1:0];
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    load = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, dig_reg, sym_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/onds_checker.sv -----
// ----------------------------------------------------------------------------
// onds_checker
// port-level checks of the digit symbol stream, bound to the top level
// ----------------------------------------------------------------------------
module onds_checker
    import onds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a number in conversion blocks the next one
    a_one_number: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a number is in conversion");

    // only the final digit of a number can still wait once input is open
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("non-final digit pending while input is open");

    // digit value in range, pad bits zero
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:16] <= 6'd36 && m_tdata[23:22] == 2'b00)
        else $error("digit value out of range");

endmodule

bind order_number_to_digit_symbols onds_checker u_onds_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/onds_digit_checker.sv -----
// ----------------------------------------------------------------------------
// onds_digit_checker
// watches the order, digit and register channels of the digit symbol block,
// works out the digit words each accepted order number must give and compares
// every accepted output word with the oldest one still due
// ----------------------------------------------------------------------------
module onds_digit_checker
    import onds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,    // order_value
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,    // symbol_code, digit_value
    input  logic                  m_tlast,    // last_digit
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    words_outstanding
);

    localparam int TABLE_DEPTH = 12;
    localparam int DIGITS_MAX  = 32;

    typedef struct packed {
        logic [SYMBOL_W-1:0] code;
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } digit_word_t;

    // shadow of the register file, kept from the observed writes
    logic [DIGIT_W-1:0]  radix_reg;
    logic                table_mode;
    logic [SYMBOL_W-1:0] zero_code;
    logic [63:0]         sym_lo;
    logic [63:0]         sym_mid;
    logic [63:0]         sym_hi;

    digit_word_t words_due[$];
    digit_word_t want;

    function automatic logic [SYMBOL_W-1:0] code_of_digit(input logic [DIGIT_W-1:0] d);
        logic [191:0] tbl;
        tbl = {sym_hi, sym_mid, sym_lo};
        if (!table_mode)
        begin
            return zero_code + {{(SYMBOL_W-DIGIT_W){1'b0}}, d};
        end
        if (int'(d) < TABLE_DEPTH)
        begin
            return tbl[int'(d)*SYMBOL_W +: SYMBOL_W];
        end
        return '0;
    endfunction

    // split one order number into digits and queue them most significant first
    function automatic void queue_order_digits(input logic [31:0] order);
        logic [DIGIT_W-1:0] radix;
        logic [31:0]        rest;
        logic [DIGIT_W-1:0] low_first [DIGITS_MAX];
        digit_word_t        w;
        int                 n;
        int                 k;
        radix = radix_reg;
        if (radix < BASE_MIN)
        begin
            radix = BASE_MIN;
        end
        else if (radix > BASE_MAX)
        begin
            radix = BASE_MAX;
        end
        rest = order;
        n = 0;
        do
        begin
            low_first[n] = DIGIT_W'(rest % {26'd0, radix});
            rest = rest / {26'd0, radix};
            n++;
        end
        while (rest != 0 && n < DIGITS_MAX);
        for (k = n - 1; k >= 0; k--)
        begin
            w.digit = low_first[k];
            w.code  = code_of_digit(low_first[k]);
            w.last  = (k == 0);
            words_due.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      = 6'd26;
            table_mode     = 1'b0;
            zero_code      = 16'd97;
            sym_lo         = '0;
            sym_mid        = '0;
            sym_hi         = '0;
            mismatch_count = 0;
            words_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_DIGIT_BASE:   radix_reg  = pwdata[DIGIT_W-1:0];
                    REG_USE_TABLE:    table_mode = pwdata[0];
                    REG_RANGE_START:  zero_code  = pwdata[SYMBOL_W-1:0];
                    REG_SYMBOLS_LOW:  sym_lo     = pwdata;
                    REG_SYMBOLS_MID:  sym_mid    = pwdata;
                    REG_SYMBOLS_HIGH: sym_hi     = pwdata;
                    default: ;
                endcase
            end
            // output first, so a new order never masks a stray word
            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    $error("word with no digit due: tdata %h tlast %b", m_tdata, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (m_tdata[SYMBOL_W-1:0] !== want.code)
                    begin
                        $error("symbol_code mismatch: expected %h, actual %h",
                               want.code, m_tdata[SYMBOL_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[SYMBOL_W +: DIGIT_W] !== want.digit)
                    begin
                        $error("digit_value mismatch: expected %0d, actual %0d",
                               want.digit, m_tdata[SYMBOL_W +: DIGIT_W]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_digit mismatch: expected %b, actual %b",
                               want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                queue_order_digits(s_tdata);
            end
        end
        words_outstanding = words_due.size();
    end

endmodule

// ----- tb/order_number_to_digit_symbols_tb.sv -----
// ----------------------------------------------------------------------------
// order_number_to_digit_symbols_tb
// drives order numbers and register writes into the digit symbol block with
// random gaps on the input and random stalls on the output; the checker
// beside the block predicts every digit word and counts mismatches
// ----------------------------------------------------------------------------
module order_number_to_digit_symbols_tb;

    import onds_pkg::*;

    // slowest legal run: ~385 orders x 32 words with sink stalls,
    // plus source gaps and the long hold-off, all inside the limit with margin
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int ORDERS_PER_PHASE = 45;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;     // order_value
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;     // symbol_code, digit_value
    logic                  m_tlast;     // last_digit
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int words_outstanding;

    // stimulus knobs; sink_steady and hold_off_go are shared with the sink process
    bit source_steady;
    bit sink_steady;
    bit hold_off_go;

    order_number_to_digit_symbols dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    onds_digit_checker digit_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: a stuck handshake or lost word ends the run here
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // mostly back-to-back, now and then a short or long pause
    function automatic int pick_pause(input bit steady);
        int sel;
        if (steady)
        begin
            return 0;
        end
        sel = $urandom_range(0, 19);
        if (sel < 12)
        begin
            return 0;
        end
        if (sel < 19)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // random order numbers: full range, small ones, shifted ones and
    // values right at a power of the base, where the digit count changes
    function automatic logic [31:0] pick_order(input logic [DIGIT_W-1:0] radix);
        int          sel;
        int          k;
        logic [63:0] r;
        logic [63:0] p;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            return $urandom();
        end
        if (sel < 7)
        begin
            return $urandom_range(0, 1000);
        end
        if (sel < 8)
        begin
            return $urandom() >> $urandom_range(0, 31);
        end
        r = (radix < BASE_MIN) ? 64'd2 : (radix > BASE_MAX) ? 64'd37 : {58'd0, radix};
        p = 64'd1;
        k = $urandom_range(1, 32);
        repeat (k)
        begin
            if (p * r <= 64'hFFFF_FFFF)
            begin
                p = p * r;
            end
        end
        return 32'(p - 64'($urandom_range(0, 1)));
    endfunction

    // one register write: setup cycle, access cycle, back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // offer one order word and hold it until the block takes it;
    // called and returning at a falling edge
    task automatic offer_order(input logic [31:0] order);
        int pause;
        pause = pick_pause(source_steady);
        if (pause > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= order;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering, wait for every due digit word, then let the block settle
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (words_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic pick_idling();
        source_steady = ($urandom_range(0, 3) == 0);
        sink_steady   = ($urandom_range(0, 3) == 0);
    endtask

    // digit sink: random stalls, plus one long hold-off on request so the
    // block backs up and drops s_tready while orders keep coming
    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_taken;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_pause(sink_steady);
            end
        end
    end

    initial
    begin
        int                 ph;
        int                 i;
        int                 sel;
        logic [DIGIT_W-1:0] radix;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        hold_off_go   = 1'b0;
        rst_n         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: base 26, letters from 'a'; zero, one, the digit
        // count boundaries and the all-ones and top-bit values
        pick_idling();
        offer_order(32'd0);
        offer_order(32'd1);
        offer_order(32'd25);
        offer_order(32'd26);
        offer_order(32'd675);
        offer_order(32'd676);
        offer_order(32'hFFFF_FFFF);
        offer_order(32'h8000_0000);
        drain_block();

        // smallest base: all-ones needs the full 32 digits
        write_reg(REG_DIGIT_BASE, 64'd2);
        write_reg(REG_RANGE_START, 64'h30);
        pick_idling();
        offer_order(32'hFFFF_FFFF);
        offer_order(32'd5);
        offer_order(32'd0);
        drain_block();

        // largest base in table mode: digits past the table give code 0
        write_reg(REG_DIGIT_BASE, 64'd37);
        write_reg(REG_USE_TABLE, 64'd1);
        write_reg(REG_SYMBOLS_LOW, 64'h0033_0032_0031_0030);
        write_reg(REG_SYMBOLS_MID, 64'h0037_0036_0035_0034);
        write_reg(REG_SYMBOLS_HIGH, 64'hFFFF_0061_0039_0038);
        pick_idling();
        offer_order(32'd36);
        offer_order(32'd11);
        offer_order(32'd12);
        offer_order(32'd1368);
        offer_order(32'hFFFF_FFFF);
        drain_block();

        // base below range behaves as 2
        write_reg(REG_DIGIT_BASE, 64'd0);
        offer_order(32'd6);
        drain_block();
        write_reg(REG_DIGIT_BASE, 64'd1);
        offer_order(32'd3);
        drain_block();

        // base above range behaves as 37
        write_reg(REG_DIGIT_BASE, 64'd38);
        offer_order(32'd1368);
        drain_block();
        write_reg(REG_DIGIT_BASE, 64'd63);
        offer_order(32'hFFFF_FFFF);
        drain_block();

        // base 12: every table entry in use, last entry reached
        write_reg(REG_DIGIT_BASE, 64'd12);
        offer_order(32'd11);
        offer_order(32'd143);
        drain_block();

        // range mode with the start at the top: codes wrap around 16 bits
        write_reg(REG_USE_TABLE, 64'd0);
        write_reg(REG_RANGE_START, 64'hFFFF);
        write_reg(REG_DIGIT_BASE, 64'd10);
        offer_order(32'd9);
        offer_order(32'd123456789);
        drain_block();

        // random phases, each with fresh settings and idling
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                radix = DIGIT_W'($urandom_range(10, 37));
            end
            else if (sel < 9)
            begin
                radix = DIGIT_W'($urandom_range(2, 9));
            end
            else
            begin
                radix = DIGIT_W'($urandom_range(0, 63));
            end
            write_reg(REG_DIGIT_BASE, {58'd0, radix});
            write_reg(REG_USE_TABLE, 64'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_RANGE_START, 64'($urandom_range(16'hFFE0, 16'hFFFF)));
            end
            else
            begin
                write_reg(REG_RANGE_START, 64'($urandom_range(0, 16'hFFFF)));
            end
            write_reg(REG_SYMBOLS_LOW, {$urandom(), $urandom()});
            write_reg(REG_SYMBOLS_MID, {$urandom(), $urandom()});
            write_reg(REG_SYMBOLS_HIGH, {$urandom(), $urandom()});
            pick_idling();
            for (i = 0; i < ORDERS_PER_PHASE; i++)
            begin
                // long sink hold-off once, early in the first random phase
                if (ph == 0 && i == 10)
                begin
                    hold_off_go = 1'b1;
                end
                offer_order(pick_order(radix));
            end
            drain_block();
        end

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/onds_pkg.sv
rtl/onds_cfg.sv
rtl/onds_divider.sv
rtl/onds_digit_store.sv
rtl/order_number_to_digit_symbols.sv
rtl/onds_checker.sv
tb/onds_digit_checker.sv
tb/order_number_to_digit_symbols_tb.sv
